// ===== rtl/core/ahbv_pkg.sv =====
// ---------------------------------------------------------------------------
// ahbv_pkg
// Shared types, constants and constant functions of the aging
// Herschel-Bulkley viscosity pipeline.
// ---------------------------------------------------------------------------
package ahbv_pkg;

  // Fixed-point formats of the exponent path.
  localparam int FRAC_BITS = 24;
  localparam int LOG_CELLS = 24;
  localparam int EXP_CELLS = 24;
  localparam int DIV_CELLS = 32;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] TERM_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] AT_LIMIT = 64'h0000_0100_0000_0000;
  localparam logic signed [35:0] Y_LIM = 36'sd1342177280;  // 80.0 in Q.24
  localparam logic signed [8:0] Y_INT = 9'sd80;

  // Register map of the configuration port.
  typedef enum logic [2:0] {
    REG_CONSISTENCY = 3'd0,
    REG_FLOW_INDEX  = 3'd1,
    REG_YIELD       = 3'd2,
    REG_CAP         = 3'd3,
    REG_AGING       = 3'd4
  } reg_idx_t;

  // Payload of one input transfer.
  typedef struct packed {
    logic [31:0] strain_rate;
    logic [31:0] sim_time;
  } req_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic [31:0] viscosity;
    logic        capped;
  } rsp_t;

  // Sideband that rides along every cell of the pipeline.
  typedef struct packed {
    logic               valid;
    logic [31:0]        rate;
    logic               zero_term;
    logic               ovf;
    logic signed [35:0] y;
  } side_t;

  // Data word of a log2 squaring cell.
  typedef struct packed {
    logic [31:0] x;
    logic [23:0] frac;
  } sqr_t;

  // Data word of an exponent mantissa cell.
  typedef struct packed {
    logic [31:0]       m;
    logic [23:0]       f;
    logic signed [8:0] i;
  } exp_t;

  // Data word of a restoring division cell.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] feed;
    logic [31:0] q;
    logic [31:0] den;
  } div_t;

  // Floor square root, one result bit per iteration.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rv;
    logic [63:0] res;
    logic [63:0] b;
    rv  = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rv >= res + b) begin
        rv  = rv - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Factor 2^(2^-j) in Q2.30, built by repeated floor square roots of 2.0.
  function automatic logic [31:0] root_factor(input int j);
    logic [63:0] c;
    c = 64'h0000_0000_8000_0000;
    for (int k = 0; k < j; k++) begin
      c = isqrt64(c << 30);
    end
    return c[31:0];
  endfunction

endpackage

// ===== rtl/core/ahbv_sqr_cell.sv =====
// ---------------------------------------------------------------------------
// ahbv_sqr_cell
// One step of the log2 fraction: squares the mantissa and yields one bit.
// ---------------------------------------------------------------------------
module ahbv_sqr_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ahbv_pkg::side_t side_in,
  input  ahbv_pkg::sqr_t  data_in,
  output ahbv_pkg::side_t side_out,
  output ahbv_pkg::sqr_t  data_out
);

  logic [63:0] sq;
  logic [32:0] sq_top;
  ahbv_pkg::sqr_t data_next;

  // Square in Q1.31 and renormalize when the value reaches 2.0.
  always_comb begin
    sq     = data_in.x * data_in.x;
    sq_top = sq[63:31];
    data_next.frac = {data_in.frac[22:0], sq_top[32]};
    data_next.x    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
    end
    if (en) begin
      data_out <= data_next;
    end
  end

endmodule

// ===== rtl/core/ahbv_exp_cell.sv =====
// ---------------------------------------------------------------------------
// ahbv_exp_cell
// One step of 2^frac: multiplies in a root-of-two factor when its bit is set.
// ---------------------------------------------------------------------------
module ahbv_exp_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [31:0]     factor,
  input  ahbv_pkg::side_t side_in,
  input  ahbv_pkg::exp_t  data_in,
  output ahbv_pkg::side_t side_out,
  output ahbv_pkg::exp_t  data_out
);

  logic [63:0] prod;
  ahbv_pkg::exp_t data_next;

  // The leading fraction bit selects this cell's factor.
  always_comb begin
    prod = data_in.m * factor;
    data_next.m = data_in.f[23] ? prod[61:30] : data_in.m;
    data_next.f = {data_in.f[22:0], 1'b0};
    data_next.i = data_in.i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
    end
    if (en) begin
      data_out <= data_next;
    end
  end

endmodule

// ===== rtl/core/ahbv_div_cell.sv =====
// ---------------------------------------------------------------------------
// ahbv_div_cell
// One restoring division step: brings down one bit and yields one quotient bit.
// ---------------------------------------------------------------------------
module ahbv_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ahbv_pkg::side_t side_in,
  input  ahbv_pkg::div_t  data_in,
  output ahbv_pkg::side_t side_out,
  output ahbv_pkg::div_t  data_out
);

  logic [32:0] trial;
  logic        take;
  logic [32:0] diff;
  ahbv_pkg::div_t data_next;

  // Compare the shifted remainder with the divisor and subtract on success.
  always_comb begin
    trial = {data_in.rem, data_in.feed[31]};
    diff  = trial - {1'b0, data_in.den};
    take  = trial >= {1'b0, data_in.den};
    data_next.rem  = take ? diff[31:0] : trial[31:0];
    data_next.feed = {data_in.feed[30:0], 1'b0};
    data_next.q    = {data_in.q[30:0], take};
    data_next.den  = data_in.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
    end
    if (en) begin
      data_out <= data_next;
    end
  end

endmodule

// ===== rtl/core/aging_herschel_bulkley_viscosity.sv =====
// ---------------------------------------------------------------------------
// aging_herschel_bulkley_viscosity
// Herschel-Bulkley viscosity with a consistency that ages exponentially.
// ---------------------------------------------------------------------------
// The block takes one cell per clock cycle while the pipeline advances, and
// results stay in order. Each cell passes three rows of cells: 24 squaring
// cells for the log2 fraction, 24 multiply cells for the power of two and
// 32 restoring division cells, plus the multiply, shift and compare stages
// between them. The whole pipeline advances whenever the output register is
// empty or its result is taken; req_stall is high only while a result waits
// in the output register and rsp_stall is high. The user must write the
// registers through the APB-style port only while the pipeline is empty; the
// block itself does not enforce this.
module aging_herschel_bulkley_viscosity (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ahbv_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ahbv_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  // Configuration registers.
  logic [31:0] consistency;
  logic [18:0] flow_index;
  logic [31:0] yield_stress;
  logic [31:0] viscosity_cap;
  logic [31:0] aging_rate;
  ahbv_pkg::reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = ahbv_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      consistency   <= '0;
      flow_index    <= 19'd65536;
      yield_stress  <= '0;
      viscosity_cap <= '1;
      aging_rate    <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        ahbv_pkg::REG_CONSISTENCY: consistency   <= pwdata;
        ahbv_pkg::REG_FLOW_INDEX:  flow_index    <= pwdata[18:0];
        ahbv_pkg::REG_YIELD:       yield_stress  <= pwdata;
        ahbv_pkg::REG_CAP:         viscosity_cap <= pwdata;
        ahbv_pkg::REG_AGING:       aging_rate    <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_sel)
      ahbv_pkg::REG_CONSISTENCY: prdata = consistency;
      ahbv_pkg::REG_FLOW_INDEX:  prdata = {13'd0, flow_index};
      ahbv_pkg::REG_YIELD:       prdata = yield_stress;
      ahbv_pkg::REG_CAP:         prdata = viscosity_cap;
      ahbv_pkg::REG_AGING:       prdata = aging_rate;
      default:                   prdata = '0;
    endcase
  end

  // Global advance of the pipeline.
  logic advance;
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = !advance;

  // Input stage.
  logic        s0_valid;
  logic [31:0] s0_rate;
  logic [31:0] s0_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= req_valid;
    end
    if (advance) begin
      s0_rate <= req.strain_rate;
      s0_time <= req.sim_time;
    end
  end

  // Stage 1: a*t and normalization of the strain rate.
  logic              a_neg;
  logic [32:0]       a_mag;
  logic [5:0]        msb;
  logic [31:0]       norm_x;
  logic signed [5:0] norm_int;
  logic              s1_valid;
  logic [31:0]       s1_rate;
  logic [63:0]       s1_at;
  logic [31:0]       s1_x;
  logic signed [5:0] s1_int;

  always_comb begin
    a_neg = aging_rate[31];
    a_mag = a_neg ? (33'h1_0000_0000 - {1'b0, aging_rate}) : {1'b0, aging_rate};
    msb = '0;
    for (int p = 0; p < 32; p++) begin
      if (s0_rate[p]) begin
        msb = 6'(p);
      end
    end
    norm_x   = (s0_rate == '0) ? 32'h8000_0000 : (s0_rate << (5'd31 - msb[4:0]));
    norm_int = (s0_rate == '0) ? 6'sd0 : 6'($signed({1'b0, msb}) - 7'sd16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
    end
    if (advance) begin
      s1_rate <= s0_rate;
      s1_at   <= {31'd0, a_mag} * {32'd0, s0_time};
      s1_x    <= norm_x;
      s1_int  <= norm_int;
    end
  end

  // Stage 2: scale a*t by log2(e).
  logic [63:0]        at_sat;
  logic [63:0]        ya_prod;
  logic [33:0]        ya_mag;
  ahbv_pkg::side_t    s2_side;
  ahbv_pkg::sqr_t     s2_data;
  logic signed [5:0]  s2_int;

  always_comb begin
    at_sat  = (s1_at > ahbv_pkg::AT_LIMIT) ? ahbv_pkg::AT_LIMIT : s1_at;
    ya_prod = at_sat[40:8] * ahbv_pkg::LOG2E_Q30;
    ya_mag  = ya_prod[63:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.valid <= 1'b0;
    end else if (advance) begin
      s2_side.valid <= s1_valid;
    end
    if (advance) begin
      s2_side.rate      <= s1_rate;
      s2_side.zero_term <= (s1_rate == '0) && (flow_index != '0);
      s2_side.ovf       <= 1'b0;
      s2_side.y         <= a_neg ? -$signed({2'b00, ya_mag}) : $signed({2'b00, ya_mag});
      s2_data.x         <= s1_x;
      s2_data.frac      <= '0;
      s2_int            <= s1_int;
    end
  end

  // Row of log2 squaring cells; the integer part rides alongside.
  ahbv_pkg::side_t   log_side [ahbv_pkg::LOG_CELLS+1];
  ahbv_pkg::sqr_t    log_data [ahbv_pkg::LOG_CELLS+1];
  logic signed [5:0] log_int  [ahbv_pkg::LOG_CELLS+1];

  assign log_side[0] = s2_side;
  assign log_data[0] = s2_data;
  assign log_int[0]  = s2_int;

  for (genvar g = 0; g < ahbv_pkg::LOG_CELLS; g++) begin : g_log
    ahbv_sqr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .side_in  (log_side[g]),
      .data_in  (log_data[g]),
      .side_out (log_side[g+1]),
      .data_out (log_data[g+1])
    );
    always_ff @(posedge clk) begin
      if (advance) begin
        log_int[g+1] <= log_int[g];
      end
    end
  end

  // Stage L1: n * |log2(r)|.
  logic signed [29:0] lg;
  logic [28:0]        lg_mag;
  ahbv_pkg::side_t    l1_side;
  logic [31:0]        l1_pm;
  logic               l1_neg;
  logic [47:0]        pm_prod;

  always_comb begin
    lg      = {log_int[ahbv_pkg::LOG_CELLS], log_data[ahbv_pkg::LOG_CELLS].frac};
    lg_mag  = lg[29] ? 29'(-lg) : lg[28:0];
    pm_prod = lg_mag * flow_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_side.valid <= 1'b0;
    end else if (advance) begin
      l1_side <= log_side[ahbv_pkg::LOG_CELLS];
    end
    if (advance) begin
      l1_pm  <= pm_prod[47:16];
      l1_neg <= lg[29];
    end
  end

  // Stage L2: exponent sum, clamp and split into integer and fraction.
  logic signed [35:0] y_sum;
  logic signed [35:0] y_clamp;
  logic [35:0]        y_off;
  ahbv_pkg::side_t    l2_side;
  ahbv_pkg::exp_t     l2_data;

  always_comb begin
    y_sum = l1_side.y;
    if (l1_side.rate != '0) begin
      y_sum = l1_neg ? (l1_side.y - $signed({4'd0, l1_pm}))
                     : (l1_side.y + $signed({4'd0, l1_pm}));
    end
    if (y_sum > ahbv_pkg::Y_LIM) begin
      y_clamp = ahbv_pkg::Y_LIM;
    end else if (y_sum < -ahbv_pkg::Y_LIM) begin
      y_clamp = -ahbv_pkg::Y_LIM;
    end else begin
      y_clamp = y_sum;
    end
    y_off = 36'(y_clamp + ahbv_pkg::Y_LIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_side.valid <= 1'b0;
    end else if (advance) begin
      l2_side <= l1_side;
    end
    if (advance) begin
      l2_data.m <= 32'h4000_0000;
      l2_data.f <= y_off[23:0];
      l2_data.i <= $signed({1'b0, y_off[31:24]}) - ahbv_pkg::Y_INT;
    end
  end

  // Row of exponent cells, each with its root-of-two factor.
  ahbv_pkg::side_t exp_side [ahbv_pkg::EXP_CELLS+1];
  ahbv_pkg::exp_t  exp_data [ahbv_pkg::EXP_CELLS+1];

  assign exp_side[0] = l2_side;
  assign exp_data[0] = l2_data;

  for (genvar g = 0; g < ahbv_pkg::EXP_CELLS; g++) begin : g_exp
    localparam logic [31:0] Factor = ahbv_pkg::root_factor(g + 1);
    ahbv_exp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .factor   (Factor),
      .side_in  (exp_side[g]),
      .data_in  (exp_data[g]),
      .side_out (exp_side[g+1]),
      .data_out (exp_data[g+1])
    );
  end

  // Stage E1: k times the mantissa.
  ahbv_pkg::side_t   e1_side;
  logic [63:0]       e1_prod;
  logic signed [8:0] e1_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_side.valid <= 1'b0;
    end else if (advance) begin
      e1_side <= exp_side[ahbv_pkg::EXP_CELLS];
    end
    if (advance) begin
      e1_prod <= consistency * exp_data[ahbv_pkg::EXP_CELLS].m;
      e1_i    <= exp_data[ahbv_pkg::EXP_CELLS].i;
    end
  end

  // Stage E2: scale by 2^i with saturation and add the yield term.
  logic signed [9:0] shamt;
  logic [9:0]        lshamt;
  logic [63:0]       rshift;
  logic [63:0]       term;
  ahbv_pkg::side_t   e2_side;
  logic [63:0]       e2_num;

  always_comb begin
    shamt  = 10'sd30 - 10'(e1_i);
    lshamt = 10'(-shamt);
    rshift = e1_prod >> shamt[5:0];
    if (shamt >= 10'sd64) begin
      term = '0;
    end else if (shamt >= 10'sd0) begin
      term = (rshift > ahbv_pkg::TERM_CAP) ? ahbv_pkg::TERM_CAP : rshift;
    end else if (e1_prod > (ahbv_pkg::TERM_CAP >> lshamt[5:0])) begin
      term = ahbv_pkg::TERM_CAP;
    end else begin
      term = e1_prod << lshamt[5:0];
    end
    if (e1_side.zero_term) begin
      term = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_side.valid <= 1'b0;
    end else if (advance) begin
      e2_side <= e1_side;
    end
    if (advance) begin
      e2_num <= term + {32'd0, yield_stress};
    end
  end

  // Stage E3: quotient overflow check and division setup.
  logic [31:0]     den;
  ahbv_pkg::side_t e2_tag;
  ahbv_pkg::side_t e3_side;
  ahbv_pkg::div_t  e3_data;

  assign den = (e2_side.rate == '0) ? 32'd1 : e2_side.rate;

  // The quotient overflows 16 integer bits when num >= den * 2^16.
  always_comb begin
    e2_tag     = e2_side;
    e2_tag.ovf = e2_num >= {16'd0, den, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e3_side.valid <= 1'b0;
    end else if (advance) begin
      e3_side <= e2_tag;
    end
    if (advance) begin
      e3_data.rem  <= e2_num[47:16];
      e3_data.feed <= {e2_num[15:0], 16'd0};
      e3_data.q    <= '0;
      e3_data.den  <= den;
    end
  end

  // Row of restoring division cells.
  ahbv_pkg::side_t div_side [ahbv_pkg::DIV_CELLS+1];
  ahbv_pkg::div_t  div_data [ahbv_pkg::DIV_CELLS+1];

  assign div_side[0] = e3_side;
  assign div_data[0] = e3_data;

  for (genvar g = 0; g < ahbv_pkg::DIV_CELLS; g++) begin : g_div
    ahbv_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .side_in  (div_side[g]),
      .data_in  (div_data[g]),
      .side_out (div_side[g+1]),
      .data_out (div_data[g+1])
    );
  end

  // Output register: saturate, apply the cap and hold until the transfer.
  logic [31:0] quot;
  logic        over_cap;

  always_comb begin
    quot     = div_side[ahbv_pkg::DIV_CELLS].ovf ? 32'hFFFF_FFFF
                                                 : div_data[ahbv_pkg::DIV_CELLS].q;
    over_cap = quot > viscosity_cap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= div_side[ahbv_pkg::DIV_CELLS].valid;
    end
    if (advance) begin
      rsp.viscosity <= over_cap ? viscosity_cap : quot;
      rsp.capped    <= over_cap;
    end
  end

endmodule

// ===== rtl/core/ahbv_checker.sv =====
// ---------------------------------------------------------------------------
// ahbv_checker
// Port-level checks of the viscosity pipeline, bound to the top level.
// ---------------------------------------------------------------------------
module ahbv_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input ahbv_pkg::rsp_t rsp,
  input logic           pready
);

  // A stalled result stays offered and unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // The input side only stalls behind a stalled result.
  a_req_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled without a stalled result");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result offered after reset");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind aging_herschel_bulkley_viscosity ahbv_checker u_ahbv_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .pready    (pready)
);

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the aging Herschel-Bulkley viscosity pipeline.
// A local bit-exact predictor computes the viscosity and cap flag of every
// accepted cell. A monitor compares each result transfer in order. Directed
// corner cells, randomized register settings, random gaps and stalls, and a
// long output hold-off that backs up the pipeline are exercised in turn.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 89;
  localparam logic [63:0] LOG2E = 64'd1549082005;
  localparam logic [63:0] POW_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] AT_MAX = 64'h0000_0100_0000_0000;
  localparam longint signed Y_MAX = 64'sd1342177280;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  ahbv_pkg::req_t req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b1;
  ahbv_pkg::rsp_t rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the register file.
  logic [31:0] k_coef = 32'd0;
  logic [18:0] n_index = 19'd65536;
  logic [31:0] tau0 = 32'd0;
  logic [31:0] nu_cap = 32'hFFFF_FFFF;
  logic [31:0] age_coef = 32'd0;

  ahbv_pkg::rsp_t expected_visc[$];
  int   error_count = 0;
  bit   no_gaps = 1'b0;
  bit   no_stalls = 1'b0;
  int   hold_off = 0;
  int   stall_left = 0;

  always #2 clk = ~clk;

  aging_herschel_bulkley_viscosity dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Floor square root, one result bit per step.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2 of a nonzero Q16.16 rate, signed Q.24.
  function automatic longint signed rate_log2(logic [31:0] r);
    int p;
    logic [63:0] x;
    longint signed frac;
    p = 31;
    frac = 0;
    while (r[p] == 1'b0) p--;
    x = 64'(r) << (31 - p);
    for (int b = 0; b < ahbv_pkg::FRAC_BITS; b++) begin
      x = (x * x) >> 31;
      frac = frac <<< 1;
      if (x >= 64'h1_0000_0000) begin
        frac = frac | 1;
        x = x >> 1;
      end
    end
    return longint'(p - 16) * (64'sd1 <<< ahbv_pkg::FRAC_BITS) + frac;
  endfunction

  // k * 2^y, raw Q16.16, saturated.
  function automatic logic [63:0] scaled_exp2(logic [31:0] k, longint signed y);
    logic [63:0] u, f, m, c, prod;
    int i, s;
    if (y > Y_MAX) y = Y_MAX;
    if (y < -Y_MAX) y = -Y_MAX;
    u = 64'(y + Y_MAX);
    i = int'(u >> ahbv_pkg::FRAC_BITS) - 80;
    f = u & 64'hFF_FFFF;
    m = 64'd1 << 30;
    c = 64'd2 << 30;
    for (int b = ahbv_pkg::FRAC_BITS - 1; b >= 0; b--) begin
      c = floor_sqrt(c << 30);
      if (f[b]) m = (m * c) >> 30;
    end
    prod = 64'(k) * m;
    s = 30 - i;
    if (s >= 64) return 64'd0;
    if (s >= 0) begin
      prod = prod >> s;
      return (prod > POW_CAP) ? POW_CAP : prod;
    end
    if (prod > (POW_CAP >> (-s))) return POW_CAP;
    return prod << (-s);
  endfunction

  // Predicted result of one cell under the current register values.
  function automatic ahbv_pkg::rsp_t predict_viscosity(ahbv_pkg::req_t c);
    logic [31:0] r, t;
    logic        a_neg;
    logic [63:0] a_mag, at, ya, pterm, num, den, q, val, pm, lmag;
    longint signed y, l;
    ahbv_pkg::rsp_t o;
    r = c.strain_rate;
    t = c.sim_time;
    a_neg = age_coef[31];
    a_mag = a_neg ? (64'h1_0000_0000 - 64'(age_coef)) : 64'(age_coef);
    at = a_mag * 64'(t);
    if (at > AT_MAX) at = AT_MAX;
    ya = ((at >> 8) * LOG2E) >> 30;
    y = a_neg ? -longint'(ya) : longint'(ya);
    if (r == 0 && n_index != 0) begin
      pterm = 64'd0;
    end else begin
      if (r != 0) begin
        l = rate_log2(r);
        lmag = (l < 0) ? 64'(-l) : 64'(l);
        pm = (lmag * 64'(n_index)) >> 16;
        y = (l < 0) ? y - longint'(pm) : y + longint'(pm);
      end
      pterm = scaled_exp2(k_coef, y);
    end
    num = 64'(tau0) + pterm;
    den = (r == 0) ? 64'd1 : 64'(r);
    q = num / den;
    if (q >= 64'd65536) val = 64'hFFFF_FFFF;
    else val = (q << 16) + (((num % den) << 16) / den);
    o.capped = (val > 64'(nu_cap));
    o.viscosity = o.capped ? nu_cap : val[31:0];
    return o;
  endfunction

  // Receiver: random stalls per result, plus an optional long hold-off.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      rsp_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rsp_stall <= 1'b0;
      stall_left <= no_stalls ? 0 : $urandom_range(0, 5);
    end
  end

  // Monitor: compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    ahbv_pkg::rsp_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_visc.size() == 0) begin
        $error("unexpected result viscosity=%h capped=%b", rsp.viscosity, rsp.capped);
        error_count++;
      end else begin
        exp_r = expected_visc.pop_front();
        if (rsp.viscosity !== exp_r.viscosity) begin
          $error("viscosity expected %h actual %h", exp_r.viscosity, rsp.viscosity);
          error_count++;
        end
        if (rsp.capped !== exp_r.capped) begin
          $error("capped expected %b actual %b", exp_r.capped, rsp.capped);
          error_count++;
        end
      end
    end
  end

  // Offer one cell and wait for its transfer.
  task automatic send_cell(logic [31:0] rate, logic [31:0] t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{strain_rate: rate, sim_time: t};
    do @(posedge clk); while (req_stall);
    expected_visc.push_back(predict_viscosity(req));
  endtask

  // Lower valid and wait until every result is back.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_visc.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(ahbv_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ahbv_pkg::REG_CONSISTENCY: k_coef = value;
      ahbv_pkg::REG_FLOW_INDEX:  n_index = value[18:0];
      ahbv_pkg::REG_YIELD:       tau0 = value;
      ahbv_pkg::REG_CAP:         nu_cap = value;
      ahbv_pkg::REG_AGING:       age_coef = value;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [31:0] k, logic [18:0] n, logic [31:0] ty,
                             logic [31:0] cap, logic [31:0] age);
    write_reg(ahbv_pkg::REG_CONSISTENCY, k);
    write_reg(ahbv_pkg::REG_FLOW_INDEX, 32'(n));
    write_reg(ahbv_pkg::REG_YIELD, ty);
    write_reg(ahbv_pkg::REG_CAP, cap);
    write_reg(ahbv_pkg::REG_AGING, age);
  endtask

  // Rate mix: full range, near 1.0, tiny, and powers of two.
  function automatic logic [31:0] draw_rate();
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 16));
      1: return 32'h1_0000 + 32'($urandom_range(0, 4095)) - 32'd2048;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] draw_time();
    case ($urandom_range(0, 2))
      0: return 32'($urandom_range(0, 32'h4_0000));
      default: return $urandom;
    endcase
  endfunction

  // Corner cells: zero rate, zero flow index, extremes, cap ties.
  task automatic test_corners();
    load_config(32'h1_0000, 19'd65536, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_cell(32'd0, 32'd0);
    send_cell(32'd1, 32'd0);
    send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cell(32'h1_0000, 32'h1_0000);
    drain();
    load_config(32'hFFFF_FFFF, 19'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_cell(32'd0, 32'd0);
    send_cell(32'd0, 32'hFFFF_FFFF);
    send_cell(32'd1, 32'h1_0000);
    send_cell(32'hFFFF_FFFF, 32'd0);
    drain();
    load_config(32'h2_8000, 19'd262144, 32'h0_4000, 32'h10_0000, 32'h8000_0000);
    send_cell(32'd0, 32'd5);
    send_cell(32'd1, 32'hFFFF_FFFF);
    send_cell(32'h8000_0000, 32'h1_0000);
    send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cell(32'h0_0100, 32'd0);
    drain();
    load_config(32'd0, 19'd32768, 32'd0, 32'd0, 32'hFFFF_0000);
    send_cell(32'd0, 32'd0);
    send_cell(32'h3_0000, 32'h2_0000);
    send_cell(32'h0_0001, 32'h0_0001);
    drain();
  endtask

  // Random cells under a sequence of random and extreme settings.
  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      no_gaps = (ph == 3);
      no_stalls = (ph == 3) || (ph == 6);
      if (ph == 0)
        load_config(32'hFFFF_FFFF, 19'd262144, 32'hFFFF_FFFF, 32'h1000, 32'h8000_0000);
      else
        load_config($urandom, 19'($urandom_range(0, 262144)), $urandom,
                    ($urandom_range(0, 1) != 0) ? $urandom : 32'hFFFF_FFFF,
                    ($urandom_range(0, 1) != 0) ? $urandom
                                                : 32'($signed($urandom_range(0, 8192)) - 4096));
      for (int j = 0; j < 190; j++) send_cell(draw_rate(), draw_time());
      drain();
    end
    no_gaps = 1'b0;
    no_stalls = 1'b0;
  endtask

  // Hold the output off while cells keep coming, so the pipeline fills.
  task automatic test_backpressure();
    load_config(32'h1_8000, 19'd98304, 32'h0_2000, 32'h100_0000, 32'h0000_0800);
    no_gaps = 1'b1;
    hold_off = 300;
    for (int j = 0; j < 160; j++) send_cell(draw_rate(), draw_time());
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corners();
    test_random_settings();
    test_backpressure();
    drain();
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (error_count == 0 && expected_visc.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
